@@ src/rtd_pkg.sv @@
// Shared types, microcode table and digit helpers for the radix digit converter.
package rtd_pkg;

    localparam int RADIX_W = 6;
    localparam int CHAR_W  = 7;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] DEC_DIGITS  = 6'd10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_A    = 7'h61;
    localparam logic [CHAR_W-1:0] CHAR_NONE = 7'h00;

    // Microprogram step addresses.
    typedef enum logic [3:0] {
        S_IDLE,
        S_ZCHK,
        S_DINIT,
        S_DSTEP,
        S_COMMIT,
        S_READ,
        S_EMIT,
        S_DONE,
        S_ZERO
    } t_step;

    // Datapath operations selected by a control word.
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_DIV_INIT,
        ACT_DIV_STEP,
        ACT_COMMIT,
        ACT_READ,
        ACT_EMIT,
        ACT_EMIT_ZERO
    } t_act;

    // Jump conditions.
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_VAL_ZERO,
        C_DIV_BUSY,
        C_MORE,
        C_IDX_NZ
    } t_cond;

    typedef struct packed {
        t_act  act;
        logic  wait_in;
        logic  wait_out;
        t_cond cond;
        t_step target;
    } t_cw;

    typedef struct packed {
        logic in_ready;
        t_act act;
    } t_ctrl;

    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic val_zero;
        logic div_busy;
        logic more;
        logic idx_nz;
    } t_stat;

    // Control store: one word per step.
    function automatic t_cw ucode(input t_step s);
        t_cw w;
        w = '{act: ACT_NONE, wait_in: 1'b0, wait_out: 1'b0, cond: C_ALWAYS, target: S_IDLE};
        unique case (s)
            S_IDLE:   w = '{ACT_LOAD,      1'b1, 1'b0, C_NEVER,    S_IDLE};
            S_ZCHK:   w = '{ACT_NONE,      1'b0, 1'b0, C_VAL_ZERO, S_ZERO};
            S_DINIT:  w = '{ACT_DIV_INIT,  1'b0, 1'b0, C_NEVER,    S_IDLE};
            S_DSTEP:  w = '{ACT_DIV_STEP,  1'b0, 1'b0, C_DIV_BUSY, S_DSTEP};
            S_COMMIT: w = '{ACT_COMMIT,    1'b0, 1'b0, C_MORE,     S_DINIT};
            S_READ:   w = '{ACT_READ,      1'b0, 1'b0, C_NEVER,    S_IDLE};
            S_EMIT:   w = '{ACT_EMIT,      1'b0, 1'b1, C_IDX_NZ,   S_READ};
            S_DONE:   w = '{ACT_NONE,      1'b0, 1'b0, C_ALWAYS,   S_IDLE};
            S_ZERO:   w = '{ACT_EMIT_ZERO, 1'b0, 1'b1, C_ALWAYS,   S_IDLE};
            default:  w = '{ACT_NONE,      1'b0, 1'b0, C_ALWAYS,   S_IDLE};
        endcase
        return w;
    endfunction

    // Radix values outside 2..36 are pinned to the nearest end.
    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] c;
        c = r;
        if (r < RADIX_MIN) c = RADIX_MIN;
        if (r > RADIX_MAX) c = RADIX_MAX;
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DEC_DIGITS) c = CHAR_ZERO + {1'b0, d};
        else                c = CHAR_A + {1'b0, d} - {1'b0, DEC_DIGITS};
        return c;
    endfunction

endpackage

@@ src/rtd_ifs.sv @@
// Valid/ready channel interfaces for input values, output digits and the radix register.
interface rtd_in_if #(parameter int VALUE_WIDTH = 31);
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] value;
    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface rtd_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] digit_char;
    logic       is_last;
    logic       no_digits;
    modport source (output valid, output digit_char, output is_last, output no_digits,
                    input ready);
    modport sink   (input valid, input digit_char, input is_last, input no_digits,
                    output ready);
endinterface

interface rtd_cfg_if;
    logic       valid;
    logic       ready;
    logic [5:0] radix;
    modport source (output valid, output radix, input ready);
    modport sink   (input valid, input radix, output ready);
endinterface

@@ src/rtd_seq.sv @@
// Microcode sequencer: step counter, control store lookup and conditional jumps.
module rtd_seq
    import rtd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_stat,
    output t_ctrl o_ctrl
);

    t_step r_pc;
    t_step n_pc;
    t_cw   cw;
    logic  stall;
    logic  take;

    assign cw    = ucode(r_pc);
    assign stall = (cw.wait_in && !i_stat.in_valid) || (cw.wait_out && !i_stat.out_free);

    always_comb begin
        unique case (cw.cond)
            C_NEVER:    take = 1'b0;
            C_ALWAYS:   take = 1'b1;
            C_VAL_ZERO: take = i_stat.val_zero;
            C_DIV_BUSY: take = i_stat.div_busy;
            C_MORE:     take = i_stat.more;
            C_IDX_NZ:   take = i_stat.idx_nz;
            default:    take = 1'b1;
        endcase
    end

    // Next step.
    always_comb begin
        if (stall) begin
            n_pc = r_pc;
        end else if (take) begin
            n_pc = cw.target;
        end else begin
            n_pc = t_step'(r_pc + 4'd1);
        end
    end

    // Control outputs.
    always_comb begin
        o_ctrl.in_ready = cw.wait_in;
        o_ctrl.act      = stall ? ACT_NONE : cw.act;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

@@ src/rtd_dp.sv @@
// Datapath: radix register, bit-serial divider, digit memory and output register.
module rtd_dp
    import rtd_pkg::*;
#(
    parameter int VALUE_WIDTH = 31,
    parameter int MAX_DIGITS  = 31
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_ctrl                  i_ctrl,
    input  logic                   i_in_valid,
    input  logic [VALUE_WIDTH-1:0] i_value,
    input  logic                   i_cfg_we,
    input  logic [RADIX_W-1:0]     i_cfg_radix,
    input  logic                   i_out_ready,
    output t_stat                  o_stat,
    output logic                   o_out_valid,
    output logic [CHAR_W-1:0]      o_out_char,
    output logic                   o_out_last,
    output logic                   o_out_none
);

    localparam int BW = $clog2(VALUE_WIDTH);
    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam int IW = $clog2(MAX_DIGITS);

    logic [RADIX_W-1:0]     r_radix;
    logic [VALUE_WIDTH-1:0] r_val;
    logic [VALUE_WIDTH-1:0] r_quo;
    logic [RADIX_W-1:0]     r_rem;
    logic [BW-1:0]          r_bit;
    logic [CW-1:0]          r_cnt;
    logic [IW-1:0]          r_idx;
    logic [RADIX_W-1:0]     r_rd;
    logic                   r_out_valid;
    logic [CHAR_W-1:0]      r_out_char;
    logic                   r_out_last;
    logic                   r_out_none;

    logic [RADIX_W-1:0]     mem [MAX_DIGITS];

    logic [RADIX_W:0]       trial;
    logic                   q_bit;
    logic                   out_free;

    // One restoring division step: remainder stays below the radix.
    assign trial = {r_rem, r_quo[VALUE_WIDTH-1]};
    assign q_bit = (trial >= {1'b0, r_radix});
    assign out_free = !r_out_valid || i_out_ready;

    assign o_stat.in_valid = i_in_valid;
    assign o_stat.out_free = out_free;
    assign o_stat.val_zero = (r_val == '0);
    assign o_stat.div_busy = (r_bit != BW'(VALUE_WIDTH - 1));
    assign o_stat.more     = (r_quo != '0) && (r_cnt != CW'(MAX_DIGITS - 1));
    assign o_stat.idx_nz   = (r_idx != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
        end else if (i_cfg_we) begin
            r_radix <= clamp_radix(i_cfg_radix);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_val       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (i_ctrl.act)
                ACT_LOAD: begin
                    r_val <= i_value;
                    r_cnt <= '0;
                end
                ACT_COMMIT: begin
                    r_val <= r_quo;
                    r_cnt <= r_cnt + 1'b1;
                end
                default: ;
            endcase
            if (i_ctrl.act == ACT_EMIT || i_ctrl.act == ACT_EMIT_ZERO) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_ctrl.act)
            ACT_DIV_INIT: begin
                r_quo <= r_val;
                r_rem <= '0;
                r_bit <= '0;
            end
            ACT_DIV_STEP: begin
                r_quo <= {r_quo[VALUE_WIDTH-2:0], q_bit};
                r_rem <= q_bit ? RADIX_W'(trial - {1'b0, r_radix}) : trial[RADIX_W-1:0];
                r_bit <= r_bit + 1'b1;
            end
            ACT_COMMIT: begin
                r_idx <= r_cnt[IW-1:0];
            end
            ACT_EMIT: begin
                r_out_char <= digit_to_char(r_rd);
                r_out_last <= (r_idx == '0);
                r_out_none <= 1'b0;
                r_idx      <= r_idx - 1'b1;
            end
            ACT_EMIT_ZERO: begin
                r_out_char <= CHAR_NONE;
                r_out_last <= 1'b1;
                r_out_none <= 1'b1;
            end
            default: ;
        endcase
    end

    // Digit memory, least significant digit at address zero.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.act == ACT_COMMIT) begin
            mem[r_cnt[IW-1:0]] <= r_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.act == ACT_READ) begin
            r_rd <= mem[r_idx];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_out_last  = r_out_last;
    assign o_out_none  = r_out_none;

endmodule

@@ src/integer_to_radix_digits.sv @@
// A value is taken, checked for zero and then divided by the radix on the bit-serial divider
// once per digit, each remainder going to the digit memory; the digits are then read back and
// emitted most significant first. Zero skips the divider and yields a single no-digit item.
// One value is in flight at a time; the bit-serial divider sets the throughput unless the output stalls.
// Synchronous active-low reset returns the sequencer to idle, sets the radix to 10 and empties
// the output register; the digit memory is not cleared.
module integer_to_radix_digits
    import rtd_pkg::*;
#(
    parameter int VALUE_WIDTH = 31,
    parameter int MAX_DIGITS  = 31
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    rtd_in_if.sink         i_value_ch,
    rtd_cfg_if.sink        i_cfg_ch,
    rtd_out_if.source      o_digit_ch
);

    t_ctrl ctrl;
    t_stat stat;
    logic  out_valid;
    logic  [CHAR_W-1:0] out_char;
    logic  out_last;
    logic  out_none;

    rtd_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    rtd_dp #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_DIGITS  (MAX_DIGITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_in_valid  (i_value_ch.valid),
        .i_value     (i_value_ch.value),
        .i_cfg_we    (i_cfg_ch.valid),
        .i_cfg_radix (i_cfg_ch.radix),
        .i_out_ready (o_digit_ch.ready),
        .o_stat      (stat),
        .o_out_valid (out_valid),
        .o_out_char  (out_char),
        .o_out_last  (out_last),
        .o_out_none  (out_none)
    );

    assign i_value_ch.ready      = ctrl.in_ready;
    assign i_cfg_ch.ready        = 1'b1;
    assign o_digit_ch.valid      = out_valid;
    assign o_digit_ch.digit_char = out_char;
    assign o_digit_ch.is_last    = out_last;
    assign o_digit_ch.no_digits  = out_none;

    // Once a word is taken, the converter is busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_value_ch.valid && i_value_ch.ready) |=> !i_value_ch.ready)
        else $error("input accepted while a conversion was starting");

    // A zero result is a single marked item with no character.
    a_zero_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && out_none) |-> (out_last && out_char == CHAR_NONE))
        else $error("malformed no-digit item");

    // Every digit item carries a legal digit character.
    a_digit_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && !out_none) |->
            ((out_char >= 7'h30 && out_char <= 7'h39) ||
             (out_char >= 7'h61 && out_char <= 7'h7a)))
        else $error("digit character out of range");

    // The divider only runs while the input side is closed.
    a_no_accept_mid_divide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.act == ACT_DIV_STEP) |-> !i_value_ch.ready)
        else $error("input open during division");

endmodule
